// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the hex frame decoder. Each macro samples on the
// rising edge of i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define HFD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define HFD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds at the edge after the antecedent.
`define HFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared types, constants and the hex digit decode of the hex frame decoder.
// ----------------------------------------------------------------------------
package hfd_pkg;

    // Default digit counts of the frame header.
    localparam int HFD_ID_DIGITS     = 2;
    localparam int HFD_LENGTH_DIGITS = 6;

    // Field widths.
    localparam int CHAR_W = 8;
    localparam int ID_W   = 8;
    localparam int LEN_W  = 24;
    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;
    localparam int KIND_W = 2;
    localparam int TDATA_W = ID_W + LEN_W + BYTE_W + LEN_W;

    // ASCII codes bounding the accepted digit ranges.
    localparam logic [CHAR_W-1:0] ASCII_0 = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_9 = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_UA = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UF = 8'h46;
    localparam logic [CHAR_W-1:0] ASCII_LA = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LF = 8'h66;
    localparam logic [NIB_W-1:0]  NIB_TEN  = 4'hA;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_BAD    = 2'd2
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    command_id;
        logic [LEN_W-1:0]   payload_length;
        logic [BYTE_W-1:0]  data_byte;
        logic [LEN_W-1:0]   byte_index;
        logic               last;
    } t_result;

    // Decoded digit: valid is low for a character that is not a hex digit.
    typedef struct packed {
        logic             valid;
        logic [NIB_W-1:0] value;
    } t_nibble;

    // Decodes one ASCII character into a nibble, either case accepted.
    function automatic t_nibble hex_value(input logic [CHAR_W-1:0] c);
        t_nibble r;
        logic [CHAR_W-1:0] d;
        r = '0;
        d = '0;
        if (c >= ASCII_0 && c <= ASCII_9) begin
            d = c - ASCII_0;
            r.valid = 1'b1;
            r.value = d[NIB_W-1:0];
        end else if (c >= ASCII_UA && c <= ASCII_UF) begin
            d = c - ASCII_UA;
            r.valid = 1'b1;
            r.value = d[NIB_W-1:0] + NIB_TEN;
        end else if (c >= ASCII_LA && c <= ASCII_LF) begin
            d = c - ASCII_LA;
            r.valid = 1'b1;
            r.value = d[NIB_W-1:0] + NIB_TEN;
        end
        return r;
    endfunction

endpackage

// ===== design/hfd_frame_core.sv =====
// ----------------------------------------------------------------------------
// hfd_frame_core
// Frame state and the per-character decode: header digit accumulation,
// payload nibble pairing, error detection and resynchronization.
// ----------------------------------------------------------------------------
module hfd_frame_core #(
    parameter int ID_DIGITS     = hfd_pkg::HFD_ID_DIGITS,
    parameter int LENGTH_DIGITS = hfd_pkg::HFD_LENGTH_DIGITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [hfd_pkg::CHAR_W-1:0] i_char,
    input  logic                    i_start,
    output logic                    o_res_valid,
    output hfd_pkg::t_result        o_res
);
    import hfd_pkg::*;

    localparam int HEADER_DIGITS = ID_DIGITS + LENGTH_DIGITS;
    localparam int POS_W         = $clog2(HEADER_DIGITS + 1);

    logic [POS_W-1:0]  r_pos, n_pos, b_pos;
    logic [ID_W-1:0]   r_id, n_id, b_id;
    logic [LEN_W-1:0]  r_len, n_len, b_len;
    logic [LEN_W-1:0]  r_count, n_count, b_count;
    logic [NIB_W-1:0]  r_high, n_high, b_high;
    logic              r_phase, n_phase, b_phase;
    logic              r_wait, n_wait;
    logic [LEN_W-1:0]  count_inc;
    t_nibble           nib;

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_high  <= '0;
            r_phase <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_id    <= n_id;
            r_len   <= n_len;
            r_count <= n_count;
            r_high  <= n_high;
            r_phase <= n_phase;
            r_wait  <= n_wait;
        end
    end

    // A start flag clears the frame before the character is handled.
    always_comb begin
        b_pos   = i_start ? '0 : r_pos;
        b_id    = i_start ? '0 : r_id;
        b_len   = i_start ? '0 : r_len;
        b_count = i_start ? '0 : r_count;
        b_high  = i_start ? '0 : r_high;
        b_phase = i_start ? 1'b0 : r_phase;
        nib       = hex_value(i_char);
        count_inc = b_count + LEN_W'(1);
    end

    // Next state and result for one character.
    always_comb begin
        n_pos       = r_pos;
        n_id        = r_id;
        n_len       = r_len;
        n_count     = r_count;
        n_high      = r_high;
        n_phase     = r_phase;
        n_wait      = r_wait;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = KIND_HEADER;

        if (i_valid && (i_start || !r_wait)) begin
            n_pos   = b_pos;
            n_id    = b_id;
            n_len   = b_len;
            n_count = b_count;
            n_high  = b_high;
            n_phase = b_phase;
            n_wait  = 1'b0;

            if (!nib.valid) begin
                // Bad character ends the frame and waits for the next start.
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_BAD;
                o_res.command_id     = b_id;
                o_res.payload_length = b_len;
                o_res.byte_index     = b_count;
                o_res.last           = 1'b1;
                n_wait               = 1'b1;
            end else if (b_pos < POS_W'(HEADER_DIGITS)) begin
                // Header digit: shift into the id or the length.
                if (b_pos < POS_W'(ID_DIGITS)) begin
                    n_id = {b_id[ID_W-NIB_W-1:0], nib.value};
                end else begin
                    n_len = {b_len[LEN_W-NIB_W-1:0], nib.value};
                end
                n_pos = b_pos + POS_W'(1);
                if (n_pos == POS_W'(HEADER_DIGITS)) begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_HEADER;
                    o_res.command_id     = n_id;
                    o_res.payload_length = n_len;
                    o_res.last           = (n_len == '0);
                    n_wait               = (n_len == '0);
                end
            end else if (!b_phase) begin
                // High nibble of a payload byte is held.
                n_high  = nib.value;
                n_phase = 1'b1;
            end else begin
                // Low nibble completes a payload byte.
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_BYTE;
                o_res.command_id     = b_id;
                o_res.payload_length = b_len;
                o_res.data_byte      = {b_high, nib.value};
                o_res.byte_index     = b_count;
                o_res.last           = (count_inc == b_len);
                n_phase              = 1'b0;
                n_high               = '0;
                n_count              = count_inc;
                n_wait               = (count_inc == b_len);
            end
        end
    end

endmodule

// ===== design/hfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// hfd_out_reg
// Result register of the decoder: holds one result until the downstream
// side takes it, and reports whether a new result can be loaded.
// ----------------------------------------------------------------------------
module hfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  hfd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output hfd_pkg::t_result o_res,
    output logic             o_free
);
    import hfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result is taken this cycle.
    assign o_free = !r_valid || i_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== design/hex_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// hex_frame_decoder
// Deframes hex-text commands arriving one ASCII character per transfer.
// ----------------------------------------------------------------------------
// The decoder takes one character per clock cycle while s_axis_tready is high.
// A character is captured in an input register and decoded against the frame
// state once the result register is free. Any result it causes is loaded into
// the result register at the end of the decode cycle, so m_axis_tvalid comes
// from the result register, which follows the input register. Back
// pressure from the result side reaches s_axis_tready only when both the
// input register and the result register are occupied and the result is not
// being taken. A frame is the command id digits, the length digits and two
// digits per payload byte. The decoder produces a header result, one result
// per payload byte, and an error result for a non-hex character. A character
// flagged in s_axis_tuser starts a new frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_frame_decoder #(
    parameter int ID_DIGITS     = hfd_pkg::HFD_ID_DIGITS,
    parameter int LENGTH_DIGITS = hfd_pkg::HFD_LENGTH_DIGITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Character stream.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [hfd_pkg::CHAR_W-1:0]  s_axis_tdata,  // [7:0] char_in
    input  logic                        s_axis_tuser,  // [0] frame_start
    // Result stream.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] command_id, [31:8] payload_length, [39:32] data_byte,
    // [63:40] byte_index
    output logic [hfd_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [hfd_pkg::KIND_W-1:0]  m_axis_tuser,  // [1:0] kind
    output logic                        m_axis_tlast
);
    import hfd_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_start;
    logic              out_free;
    logic              advance;
    logic              res_valid;
    t_result           res;
    logic              out_valid;
    t_result           out_res;

    // The held character is decoded once the result register can take it.
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    // Frame decode.
    hfd_frame_core #(
        .ID_DIGITS     (ID_DIGITS),
        .LENGTH_DIGITS (LENGTH_DIGITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_char      (r_in_char),
        .i_start     (r_in_start),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    hfd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (out_valid),
        .o_res   (out_res),
        .o_free  (out_free)
    );

    // Result stream packing.
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {out_res.byte_index, out_res.data_byte,
                            out_res.payload_length, out_res.command_id};
    assign m_axis_tuser  = out_res.kind;
    assign m_axis_tlast  = out_res.last;

    // Checks on the decoder's own results and staging.
    `HFD_ASSERT_IMPL(a_bad_is_last, out_valid && out_res.kind == KIND_BAD, out_res.last, "error result without last")
    `HFD_ASSERT_IMPL(a_hdr_last_len, out_valid && out_res.kind == KIND_HEADER, out_res.last == (out_res.payload_length == '0), "header last does not match zero length")
    `HFD_ASSERT_IMPL(a_index_range, out_valid && out_res.kind == KIND_BYTE, out_res.byte_index < out_res.payload_length, "payload byte index beyond length")
    `HFD_ASSERT_NEXT(a_in_hold, r_in_valid && !out_free, r_in_valid && $stable(r_in_char) && $stable(r_in_start), "held character lost while result side stalled")

endmodule
